>>> hdl/rlf_pkg.sv
// Shared types and constants for the resonant low-pass filter.
// Holds the control word format, the microcode program and the damping table.
// No dependencies.
package rlf_pkg;

  localparam int STEP_W = 4;
  localparam int IN_W = 19;
  localparam int CUT_W = 12;
  localparam int OUT_W = 20;
  localparam int RES_W = 5;
  localparam int GAIN_W = 10;
  localparam int SHIFT_W = 5;
  localparam int DAMP_W = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CUT_W-1:0] CUT_TOP = 12'hfff;
  localparam logic [GAIN_W-1:0] GAIN_TOP = 10'd512;
  localparam logic [SHIFT_W-1:0] SHIFT_BASE = 5'd24;
  localparam logic [SHIFT_W-1:0] DAMP_SHIFT = 5'd8;
  localparam int OUT_LIM = 262144;
  localparam logic [OUT_W-1:0] OUT_MIN = 20'h80000;
  localparam logic [OUT_W-1:0] OUT_MAX = 20'h7ffff;
  localparam logic [RES_W-1:0] RES_RESET = 5'd4;
  localparam logic [0:0] REG_RESONANCE = 1'b0;

  typedef enum logic [2:0] {
    OP_MUL_DAMP,
    OP_MUL_GAIN,
    OP_SHRC_8,
    OP_SHRF_CUT,
    OP_SHRC_CUT,
    OP_ADD,
    OP_SUB,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {A_T, A_E, A_BP, A_LP, A_X} a_sel_t;
  typedef enum logic {B_T, B_LP} b_sel_t;
  typedef enum logic [2:0] {D_NONE, D_T, D_E, D_BP, D_LP} dst_t;
  typedef enum logic {SEQ_NEXT, SEQ_DONE} seq_t;
  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  typedef struct packed {
    op_t op;
    a_sel_t a_sel;
    b_sel_t b_sel;
    dst_t dst;
    seq_t seq;
  } cw_t;

  typedef struct packed {
    logic load;
    logic step;
    cw_t cw;
  } dp_ctrl_t;

  localparam logic [DAMP_W-1:0] DAMP_TAB [32] = '{
    8'd192, 8'd176, 8'd160, 8'd144, 8'd128, 8'd120, 8'd112, 8'd104,
    8'd96, 8'd88, 8'd80, 8'd72, 8'd64, 8'd60, 8'd56, 8'd52,
    8'd48, 8'd44, 8'd40, 8'd36, 8'd32, 8'd30, 8'd28, 8'd26,
    8'd24, 8'd22, 8'd20, 8'd18, 8'd16, 8'd15, 8'd14, 8'd13
  };

  function automatic cw_t ucode(input logic [STEP_W-1:0] pc);
    cw_t w;
    w = '{op: OP_EMIT, a_sel: A_T, b_sel: B_T, dst: D_NONE, seq: SEQ_DONE};
    case (pc)
      4'd0: w = '{op: OP_MUL_DAMP, a_sel: A_BP, b_sel: B_T, dst: D_T, seq: SEQ_NEXT};
      4'd1: w = '{op: OP_SHRC_8, a_sel: A_T, b_sel: B_T, dst: D_T, seq: SEQ_NEXT};
      4'd2: w = '{op: OP_ADD, a_sel: A_T, b_sel: B_T, dst: D_T, seq: SEQ_NEXT};
      4'd3: w = '{op: OP_SUB, a_sel: A_X, b_sel: B_LP, dst: D_E, seq: SEQ_NEXT};
      4'd4: w = '{op: OP_SUB, a_sel: A_E, b_sel: B_T, dst: D_E, seq: SEQ_NEXT};
      4'd5: w = '{op: OP_MUL_GAIN, a_sel: A_E, b_sel: B_T, dst: D_T, seq: SEQ_NEXT};
      4'd6: w = '{op: OP_SHRF_CUT, a_sel: A_T, b_sel: B_T, dst: D_T, seq: SEQ_NEXT};
      4'd7: w = '{op: OP_ADD, a_sel: A_BP, b_sel: B_T, dst: D_BP, seq: SEQ_NEXT};
      4'd8: w = '{op: OP_MUL_GAIN, a_sel: A_BP, b_sel: B_T, dst: D_T, seq: SEQ_NEXT};
      4'd9: w = '{op: OP_SHRC_CUT, a_sel: A_T, b_sel: B_T, dst: D_T, seq: SEQ_NEXT};
      4'd10: w = '{op: OP_ADD, a_sel: A_LP, b_sel: B_T, dst: D_LP, seq: SEQ_NEXT};
      default: w = '{op: OP_EMIT, a_sel: A_T, b_sel: B_T, dst: D_NONE, seq: SEQ_DONE};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/rlf_seq.sv
// Microcode sequencer: step counter, program fetch and end-of-program wait.
// Depends on rlf_pkg.
module rlf_seq (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic out_free,
  output logic idle,
  output logic emit,
  output rlf_pkg::dp_ctrl_t ctrl
);

  rlf_pkg::state_t state, state_next;
  logic [rlf_pkg::STEP_W-1:0] pc, pc_next;
  rlf_pkg::cw_t cw;

  assign cw = rlf_pkg::ucode(pc);

  always_comb begin
    state_next = state;
    pc_next = pc;
    case (state)
      rlf_pkg::ST_IDLE: begin
        pc_next = '0;
        if (start) state_next = rlf_pkg::ST_RUN;
      end
      rlf_pkg::ST_RUN: begin
        if (cw.seq == rlf_pkg::SEQ_NEXT) begin
          pc_next = pc + 1'b1;
        end else if (out_free) begin
          pc_next = '0;
          state_next = rlf_pkg::ST_IDLE;
        end
      end
      default: begin
        pc_next = '0;
        state_next = rlf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    idle = (state == rlf_pkg::ST_IDLE);
    emit = (state == rlf_pkg::ST_RUN) && (cw.seq == rlf_pkg::SEQ_DONE) && out_free;
    ctrl.load = idle && start;
    ctrl.step = (state == rlf_pkg::ST_RUN) && (cw.seq == rlf_pkg::SEQ_NEXT);
    ctrl.cw = cw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlf_pkg::ST_IDLE;
      pc <= '0;
    end else begin
      state <= state_next;
      pc <= pc_next;
    end
  end

endmodule

>>> hdl/rlf_dp.sv
// Saturating datapath: one coefficient multiplier, shifter and adder over the filter registers.
// Depends on rlf_pkg; driven by the control word from rlf_seq.
module rlf_dp #(
  parameter int ACC_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  rlf_pkg::dp_ctrl_t ctrl,
  input  logic signed [rlf_pkg::IN_W-1:0] sample_in,
  input  logic [rlf_pkg::CUT_W-1:0] cutoff_code,
  input  logic [rlf_pkg::RES_W-1:0] resonance,
  output logic [rlf_pkg::OUT_W-1:0] filtered
);

  localparam int PW = ACC_WIDTH + rlf_pkg::GAIN_W + 1;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_WIDTH-1:0] LIM_HI = ACC_WIDTH'(rlf_pkg::OUT_LIM);
  localparam logic signed [ACC_WIDTH-1:0] LIM_LO = -LIM_HI;

  logic signed [ACC_WIDTH-1:0] t, e, bp, lp, x;
  logic [rlf_pkg::GAIN_W-1:0] gain;
  logic [rlf_pkg::SHIFT_W-1:0] shift;

  logic signed [ACC_WIDTH-1:0] a, b, res;
  logic [rlf_pkg::GAIN_W-1:0] coef;
  logic signed [PW-1:0] a_w, c_w, prod;
  logic signed [ACC_WIDTH-1:0] mul_sat;
  logic signed [ACC_WIDTH:0] sum;
  logic signed [ACC_WIDTH-1:0] sum_sat;
  logic [rlf_pkg::SHIFT_W-1:0] sh_amt;
  logic signed [ACC_WIDTH:0] sh_in, sh_out, mask;
  logic [rlf_pkg::OUT_W-1:0] dbl;

  always_comb begin
    case (ctrl.cw.a_sel)
      rlf_pkg::A_T: a = t;
      rlf_pkg::A_E: a = e;
      rlf_pkg::A_BP: a = bp;
      rlf_pkg::A_LP: a = lp;
      rlf_pkg::A_X: a = x;
      default: a = t;
    endcase
    b = (ctrl.cw.b_sel == rlf_pkg::B_LP) ? lp : t;
  end

  always_comb begin
    coef = (ctrl.cw.op == rlf_pkg::OP_MUL_DAMP)
         ? {2'b00, rlf_pkg::DAMP_TAB[resonance]} : gain;
    a_w = {{(PW-ACC_WIDTH){a[ACC_WIDTH-1]}}, a};
    c_w = {{(PW-rlf_pkg::GAIN_W){1'b0}}, coef};
    prod = a_w * c_w;
    if (&prod[PW-1:ACC_WIDTH-1] || ~|prod[PW-1:ACC_WIDTH-1]) begin
      mul_sat = prod[ACC_WIDTH-1:0];
    end else begin
      mul_sat = prod[PW-1] ? ACC_MIN : ACC_MAX;
    end
  end

  always_comb begin
    if (ctrl.cw.op == rlf_pkg::OP_SUB) begin
      sum = {a[ACC_WIDTH-1], a} - {b[ACC_WIDTH-1], b};
    end else begin
      sum = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
    end
    if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
      sum_sat = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum[ACC_WIDTH-1:0];
    end
  end

  always_comb begin
    sh_amt = (ctrl.cw.op == rlf_pkg::OP_SHRC_8) ? rlf_pkg::DAMP_SHIFT : shift;
    mask = ~({(ACC_WIDTH+1){1'b1}} << sh_amt);
    sh_in = {a[ACC_WIDTH-1], a};
    if (ctrl.cw.op != rlf_pkg::OP_SHRF_CUT) sh_in = sh_in + mask;
    sh_out = sh_in >>> sh_amt;
  end

  always_comb begin
    case (ctrl.cw.op)
      rlf_pkg::OP_MUL_DAMP, rlf_pkg::OP_MUL_GAIN: res = mul_sat;
      rlf_pkg::OP_SHRC_8, rlf_pkg::OP_SHRF_CUT, rlf_pkg::OP_SHRC_CUT:
        res = sh_out[ACC_WIDTH-1:0];
      rlf_pkg::OP_ADD, rlf_pkg::OP_SUB: res = sum_sat;
      default: res = t;
    endcase
  end

  always_comb begin
    dbl = {lp[rlf_pkg::OUT_W-2:0], 1'b0};
    if (lp >= LIM_HI) filtered = rlf_pkg::OUT_MIN;
    else if (lp <= LIM_LO) filtered = rlf_pkg::OUT_MAX;
    else filtered = -dbl;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= {{(ACC_WIDTH-rlf_pkg::IN_W){sample_in[rlf_pkg::IN_W-1]}}, sample_in};
      gain <= (cutoff_code == rlf_pkg::CUT_TOP) ? rlf_pkg::GAIN_TOP
            : {2'b01, cutoff_code[7:0]};
      shift <= rlf_pkg::SHIFT_BASE - {1'b0, cutoff_code[rlf_pkg::CUT_W-1:8]};
    end
    if (ctrl.step && ctrl.cw.dst == rlf_pkg::D_T) t <= res;
    if (ctrl.step && ctrl.cw.dst == rlf_pkg::D_E) e <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bp <= '0;
      lp <= '0;
    end else if (ctrl.step) begin
      if (ctrl.cw.dst == rlf_pkg::D_BP) bp <= res;
      if (ctrl.cw.dst == rlf_pkg::D_LP) lp <= res;
    end
  end

endmodule

>>> hdl/resonant_lowpass_filter_step.sv
// Top level of the resonant low-pass filter: register port, output register, sequencer, datapath.
// Depends on rlf_pkg, rlf_seq and rlf_dp.
//
// Usage: each input transfer (in_valid/in_ready) carries one sample and a cutoff code;
// each produces exactly one output transfer (out_valid/out_ready) of the filtered value.
// The block works on one sample at a time: after the input transfer the microcode
// program runs its eleven arithmetic steps through the single shared multiply, shift
// and add unit, then writes the output register. The next sample is taken only after the
// program has finished and the sequencer is back in idle, so the step count of the program
// and a stalled receiver both bound how often samples are taken.
// The output register lets the next sample be taken while a result waits. If the
// receiver stalls, the program holds on its last step until the output register is
// free, and in_ready stays low meanwhile.
// Reset clears both accumulators, empties the output register and sets the resonance
// register to 4. The user must write the resonance register (address 0) through the APB
// port only while no sample is in flight; the block does not enforce it. pready is always high.
module resonant_lowpass_filter_step #(
  parameter int ACC_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [rlf_pkg::IN_W-1:0] sample_in,
  input  logic [rlf_pkg::CUT_W-1:0] cutoff_code,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [rlf_pkg::OUT_W-1:0] filtered_out,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [rlf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rlf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rlf_pkg::CFG_DATA_W-1:0] prdata,
  output logic pready
);

  logic [rlf_pkg::RES_W-1:0] resonance;
  logic start, out_free, idle, emit;
  logic [rlf_pkg::OUT_W-1:0] filtered;
  rlf_pkg::dp_ctrl_t ctrl;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rlf_pkg::REG_RESONANCE)
                ? {{(rlf_pkg::CFG_DATA_W-rlf_pkg::RES_W){1'b0}}, resonance} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      resonance <= rlf_pkg::RES_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == rlf_pkg::REG_RESONANCE) begin
      resonance <= pwdata[rlf_pkg::RES_W-1:0];
    end
  end

  assign in_ready = idle;
  assign start = in_valid;
  assign out_free = !out_valid || out_ready;

  rlf_seq u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .out_free(out_free),
    .idle(idle),
    .emit(emit),
    .ctrl(ctrl)
  );

  rlf_dp #(.ACC_WIDTH(ACC_WIDTH)) u_dp (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .sample_in(sample_in),
    .cutoff_code(cutoff_code),
    .resonance(resonance),
    .filtered(filtered)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) filtered_out <= filtered;
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("result written while output register still full");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer did not start after input transfer");

  a_emit_shows_result: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("result written but out_valid low");

  a_emit_ends_program: assert property (@(posedge clk) disable iff (rst)
    emit |=> in_ready)
    else $error("sequencer not idle after writing result");

endmodule
